@@ hw/rtl/bls_pkg.sv @@
// Shared types and constants of the binomial lattice stencil block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bls_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 1024;

  // Field widths of the request and response channels
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SIZE_W  = 11;

  // Up weight pu is unsigned Q1.16; the integer bit is needed to hold one
  localparam int unsigned PU_W           = 17;
  localparam int unsigned PROB_FRAC_BITS = 16;
  localparam logic [PU_W-1:0] PROB_ONE   = PU_W'(1) << PROB_FRAC_BITS;
  localparam logic [PU_W-1:0] PU_RESET   = PU_W'(32768);

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_RHOMBUS  = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ hw/rtl/bls_ifs.sv @@
// Valid/ready channel interfaces for the stencil request and response.
// Depends on bls_pkg for the field widths.
`default_nettype none

interface bls_req_if
  import bls_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [ADDR_W-1:0]         address;
  logic signed [VALUE_W-1:0] write_value;
  logic [ADDR_W-1:0]         start_index;
  logic [SIZE_W-1:0]         size_a;
  logic [SIZE_W-1:0]         size_b;

  modport source (
    output valid, operation, address, write_value, start_index, size_a, size_b,
    input  ready
  );
  modport sink (
    input  valid, operation, address, write_value, start_index, size_a, size_b,
    output ready
  );
endinterface

interface bls_rsp_if
  import bls_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic                      status;

  modport source (
    output valid, read_value, status,
    input  ready
  );
  modport sink (
    input  valid, read_value, status,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/bls_update.sv @@
// Element update: registered weighted products, then floor, add and saturate.
// Depends on bls_pkg; produces the write-back port of the lattice buffer.
`default_nettype none

module bls_update
  import bls_pkg::*;
#(
  parameter int unsigned IDX_W = 10
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [IDX_W-1:0]          in_addr_i,
  input  wire logic signed [VALUE_W-1:0] prev_i,
  input  wire logic signed [VALUE_W-1:0] next_i,
  input  wire logic [PU_W-1:0]           pu_i,
  output      logic                      wr_valid_o,
  output      logic [IDX_W-1:0]          wr_addr_o,
  output      logic signed [VALUE_W-1:0] wr_data_o
);

  localparam int unsigned PROD_W = PU_W + 1 + VALUE_W;
  localparam int unsigned TERM_W = PROD_W - PROB_FRAC_BITS;
  localparam int unsigned SUM_W  = TERM_W + 1;

  logic                     valid_q;
  logic [IDX_W-1:0]         addr_q;
  logic signed [PROD_W-1:0] prod_up_q, prod_dn_q;
  logic signed [PU_W:0]     w_up, w_dn;
  logic signed [SUM_W-1:0]  sum;

  assign w_up = $signed({1'b0, pu_i});
  assign w_dn = $signed({1'b0, PROB_ONE - pu_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= in_addr_i;
    prod_up_q <= PROD_W'(w_up) * PROD_W'(next_i);
    prod_dn_q <= PROD_W'(w_dn) * PROD_W'(prev_i);
  end

  // Dropping the low fraction bits of a signed product floors it
  assign sum = SUM_W'($signed(prod_up_q[PROD_W-1:PROB_FRAC_BITS]))
             + SUM_W'($signed(prod_dn_q[PROD_W-1:PROB_FRAC_BITS]));

  always_comb begin
    if (sum[SUM_W-1:VALUE_W-1] == '0 || sum[SUM_W-1:VALUE_W-1] == '1) begin
      wr_data_o = sum[VALUE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      wr_data_o = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      wr_data_o = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  assign wr_valid_o = valid_q;
  assign wr_addr_o  = addr_q;

endmodule

`default_nettype wire

@@ hw/rtl/binomial_lattice_stencil.sv @@
// Binomial lattice stencil: buffer of Q16.16 lattice values with in-place
// backward-induction runs p[k] = pu*p[k+1] + (1-pu)*p[k].
//
// Usage: requests arrive on req_i (valid/ready); each transfer yields exactly
// one response on rsp_o. Operations: write a word, read a word, run a
// triangle of size_a-1 rows, or run a rhombus tile of size_a-1 rows of width
// size_b at start_index. Out-of-range accesses return status 1 and change
// nothing. pu must be written by the user through cfg_we_i/cfg_wdata_i only
// while the block is idle; the block does not enforce it. Writes and reads are
// accepted back to back while the receiver takes responses; each response
// passes the pending stage, then the output register. A run holds the block
// until its last row ends: one buffer read port streams a row into a two-stage
// multiply and saturate pipeline, which drains at every row boundary because
// the next row reads words the previous one wrote. An empty or refused run
// answers like a write. Reset empties the response register and sets pu to
// one half; buffer words stay undefined until written (no clearing pass).
// When the receiver stalls, one response is held in the output register, one
// more waits in the stage before it, and then req_i.ready drops.
`default_nettype none

module binomial_lattice_stencil
  import bls_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [PU_W-1:0] cfg_wdata_i,
  bls_req_if.sink              req_i,
  bls_rsp_if.source            rsp_o
);

  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);

  state_e state_q, state_d;

  // Configuration
  logic [PU_W-1:0] pu_cfg_q, pu_sat;

  // Buffer
  logic signed [VALUE_W-1:0] mem_q [BUFFER_DEPTH];
  logic signed [VALUE_W-1:0] rdata_q;
  logic                      mem_re, mem_we, ld_we;
  logic [IDX_W-1:0]          mem_raddr, mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;

  // Request decode
  op_e         op;
  logic        accept, addr_ok, is_run, run_empty, run_bad, run_go;
  logic [31:0] rho_hi;

  // Run sequencer
  logic [IDX_W-1:0]  base_q, rd_addr;
  logic [SIZE_W-1:0] len_q, idx_q, rows_q;
  logic              tri_q;
  logic              s1_valid_q, s1_first_q;
  logic [IDX_W-1:0]  s1_addr_q;
  logic signed [VALUE_W-1:0] prev_q;
  logic              drained, row_next;

  // Update pipeline write-back
  logic                      upd_valid;
  logic [IDX_W-1:0]          upd_addr;
  logic signed [VALUE_W-1:0] upd_data;

  // Response path: pending stage then output register
  logic pend_q, pend_rd_q, pend_status_q;
  logic pend_ld, pend_rd_d, pend_status_d, pend_room, pend_mv, out_free;
  logic out_valid_q, out_status_q;
  logic signed [VALUE_W-1:0] out_value_q;

  // ---------------------------------------------------------------- decode
  assign op     = op_e'(req_i.operation);
  assign accept = req_i.valid && req_i.ready;
  assign is_run = (op == OP_TRIANGLE) || (op == OP_RHOMBUS);
  assign rho_hi = 32'(req_i.start_index) + 32'(req_i.size_a) + 32'(req_i.size_b) - 32'd1;

  always_comb begin
    addr_ok   = 32'(req_i.address) < 32'(BUFFER_DEPTH);
    run_empty = 1'b0;
    run_bad   = 1'b0;
    case (op)
      OP_TRIANGLE: begin
        run_empty = req_i.size_a < SIZE_W'(2);
        run_bad   = 32'(req_i.size_a) >= 32'(BUFFER_DEPTH);
      end
      OP_RHOMBUS: begin
        run_empty = (req_i.size_a < SIZE_W'(2)) || (req_i.size_b == '0);
        run_bad   = rho_hi >= 32'(BUFFER_DEPTH);
      end
      default: begin
        run_empty = 1'b0;
        run_bad   = 1'b0;
      end
    endcase
  end

  assign run_go = is_run && !run_empty && !run_bad;

  assign pu_sat    = (pu_cfg_q > PROB_ONE) ? PROB_ONE : pu_cfg_q;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign pend_mv   = pend_q && out_free;
  assign pend_room = !pend_q || out_free;
  assign drained   = !s1_valid_q && !upd_valid;
  assign rd_addr   = base_q + IDX_W'(idx_q);

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && run_go) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (idx_q == len_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_d = (rows_q == SIZE_W'(1)) ? ST_DONE : ST_READ;
        end
      end
      ST_DONE: begin
        if (pend_room) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    req_i.ready   = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = rd_addr;
    ld_we         = 1'b0;
    pend_ld       = 1'b0;
    pend_rd_d     = 1'b0;
    pend_status_d = STATUS_OK;
    row_next      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = pend_room;
        mem_raddr   = IDX_W'(req_i.address);
        if (accept) begin
          ld_we     = (op == OP_WRITE) && addr_ok;
          mem_re    = (op == OP_READ) && addr_ok;
          pend_ld   = !run_go;
          pend_rd_d = (op == OP_READ) && addr_ok;
          if ((!is_run && !addr_ok) || (is_run && !run_empty && run_bad)) begin
            pend_status_d = STATUS_RANGE;
          end
        end
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_DRAIN: begin
        row_next = drained && (rows_q != SIZE_W'(1));
      end
      ST_DONE: begin
        pend_ld = pend_room;
      end
      default: begin
        pend_ld = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- buffer
  assign mem_we    = ld_we || upd_valid;
  assign mem_waddr = ld_we ? IDX_W'(req_i.address) : upd_addr;
  assign mem_wdata = ld_we ? req_i.write_value : upd_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // --------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pu_cfg_q    <= PU_RESET;
      s1_valid_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= (state_q == ST_READ);
      pend_q     <= pend_ld || (pend_q && !pend_mv);
      if (cfg_we_i) begin
        pu_cfg_q <= cfg_wdata_i;
      end
      if (pend_mv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (accept && run_go) begin
      tri_q  <= (op == OP_TRIANGLE);
      idx_q  <= '0;
      rows_q <= req_i.size_a - SIZE_W'(1);
      if (op == OP_TRIANGLE) begin
        base_q <= '0;
        len_q  <= req_i.size_a;
      end else begin
        base_q <= IDX_W'(32'(req_i.start_index) + 32'(req_i.size_a) - 32'd1);
        len_q  <= req_i.size_b;
      end
    end else if (state_q == ST_READ) begin
      idx_q <= idx_q + SIZE_W'(1);
    end else if (row_next) begin
      // advance to the next row: triangle shrinks, rhombus shifts down
      idx_q  <= '0;
      rows_q <= rows_q - SIZE_W'(1);
      if (tri_q) begin
        len_q <= len_q - SIZE_W'(1);
      end else begin
        base_q <= base_q - IDX_W'(1);
      end
    end
    s1_first_q <= (idx_q == '0);
    s1_addr_q  <= rd_addr;
    if (s1_valid_q) begin
      prev_q <= rdata_q;
    end
    if (pend_ld) begin
      pend_rd_q     <= pend_rd_d;
      pend_status_q <= pend_status_d;
    end
    if (pend_mv) begin
      out_value_q  <= pend_rd_q ? rdata_q : '0;
      out_status_q <= pend_status_q;
    end
  end

  // Element k pairs the held word p[k] with the word p[k+1] just read
  bls_update #(
    .IDX_W(IDX_W)
  ) u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid_q && !s1_first_q),
    .in_addr_i  (s1_addr_q - IDX_W'(1)),
    .prev_i     (prev_q),
    .next_i     (rdata_q),
    .pu_i       (pu_sat),
    .wr_valid_o (upd_valid),
    .wr_addr_o  (upd_addr),
    .wr_data_o  (upd_data)
  );

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.status     = out_status_q;

endmodule

`default_nettype wire
